@@ hdl/hagc_pkg.sv @@
// ----------------------------------------------------------------------------
// hagc_pkg
// Shared types, constants and gain tables for the histogram auto gain control.
// ----------------------------------------------------------------------------
package hagc_pkg;

   // sizing
   localparam int HIST_BINS           = 256;
   localparam int FRAMES_PER_DECISION = 5;
   localparam int GAIN_STEPS          = 8;

   localparam int BIN_IDX_W  = 8;
   localparam int BIN_CNT_W  = 24;
   localparam int AREA_W     = 32;
   localparam int TOTAL_W    = AREA_W + 2;
   localparam int SCALED_W   = AREA_W + 7;        // area * 100
   localparam int PCT_W      = 7;
   localparam int PCT_BITS   = 7;                 // quotient bits, percent <= 100
   localparam int PSTEP_W    = $clog2(PCT_BITS);
   localparam int STAT_W     = 10;
   localparam int STAT_MAX   = 1023;
   localparam int FRAMES_W   = $clog2(FRAMES_PER_DECISION + 1);
   localparam int STEP_W     = $clog2(GAIN_STEPS);
   localparam int GAIN_W     = 8;
   localparam int RAISE_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // average = floor(sum / FRAMES_PER_DECISION) via reciprocal multiply
   localparam int AVG_SHIFT  = 16;
   localparam int AVG_RECIP  = (2**AVG_SHIFT + FRAMES_PER_DECISION - 1) / FRAMES_PER_DECISION;
   localparam int AVG_PROD_W = STAT_W + AVG_SHIFT + 1;

   localparam int LAST_BIN   = HIST_BINS - 1;

   // reset values of the control registers
   localparam logic [7:0]         DARK_END_RST    = 8'd21;
   localparam logic [7:0]         BRIGHT_START_RST = 8'd253;
   localparam logic [6:0]         OVEREXP_RST     = 7'd10;
   localparam logic [RAISE_W-1:0] RAISE_LIMIT_RST = 2'd2;
   localparam logic [STEP_W-1:0]  STEP_RST        = 3'd3;

   // decision thresholds on the dark average
   localparam logic [STAT_W-1:0] DARK_TH_7 = 10'd95;
   localparam logic [STAT_W-1:0] DARK_TH_6 = 10'd90;
   localparam logic [STAT_W-1:0] DARK_TH_5 = 10'd80;
   localparam logic [STAT_W-1:0] DARK_TH_4 = 10'd70;
   localparam logic [STAT_W-1:0] DARK_TH_3 = 10'd60;

   localparam logic [GAIN_W-1:0] GAIN_TABLE_DARK [GAIN_STEPS] =
      '{8'h20, 8'h35, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0};
   localparam logic [GAIN_W-1:0] GAIN_TABLE_LIGHT [GAIN_STEPS] =
      '{8'h40, 8'h55, 8'h70, 8'h80, 8'hA0, 8'hB0, 8'hD0, 8'hF0};

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_SELECT     = 3'd0,
      CSR_DARK_BIN_END     = 3'd1,
      CSR_BRIGHT_BIN_START = 3'd2,
      CSR_OVEREXPOSED_PCT  = 3'd3,
      CSR_RAISE_LIMIT      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      AREA_DARK   = 2'd0,
      AREA_MID    = 2'd1,
      AREA_BRIGHT = 2'd2
   } area_type;

   typedef enum logic [3:0] {
      ST_ACCUM,
      ST_TOTAL,
      ST_DIV_LOAD,
      ST_DIV_STEP,
      ST_DIV_STORE,
      ST_STATS,
      ST_DECIDE,
      ST_GAIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic     acc_en;
      logic     total_en;
      logic     div_load;
      logic     div_step;
      logic     pct_store;
      area_type area_sel;
      logic     stats_acc;
      logic     stats_avg;
      logic     decide_en;
      logic     gain_en;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic last_bin;
      logic frames_zero;
      logic out_busy;
   } status_type;

endpackage

@@ hdl/histogram_auto_gain_control_unit.sv @@
// ----------------------------------------------------------------------------
// histogram_auto_gain_control_unit
// Histogram-driven sensor gain control: frame percents, averaging, decision.
// ----------------------------------------------------------------------------
// Histogram bins are taken one per clock (req_valid / req_stall). Each bin's
// count is added, saturating at 32 bits, to the dark, middle or bright area
// chosen by its index against dark_bin_end and bright_bin_start (dark wins
// where the ranges overlap). The bin at the last index closes the frame and
// stalls the input while the frame is processed: the total is formed, then
// one shared restoring divider computes floor(100*area/total) for the three
// areas in turn (a load, seven quotient steps and a store each), then the
// statistics are updated. Five frames are summed; the sixth frame averages
// them and runs the gain decision. A frame end also waits while the previous
// transaction sits unaccepted in the result register. All bins other than
// the last are taken back to back. Exactly one result transaction is issued
// per frame. The result register holds the frame percents, the decision and
// gain-write flags and the gain value and step after the frame; when
// gain_write is set the gain value must be written to the sensor. Registers
// are written through csr_wr_en / csr_index / csr_wdata; the user must do so
// only while the unit is idle, which the block does not enforce. Writing
// raise_limit also reloads the remaining raise count.
// ----------------------------------------------------------------------------
module histogram_auto_gain_control_unit (
   input  logic                                clock,
   input  logic                                reset,
   // bin input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [hagc_pkg::BIN_IDX_W-1:0]      req_bin_index,
   input  logic [hagc_pkg::BIN_CNT_W-1:0]      req_bin_count,
   // per-frame result
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hagc_pkg::PCT_W-1:0]          rsp_dark_percent,
   output logic [hagc_pkg::PCT_W-1:0]          rsp_mid_percent,
   output logic [hagc_pkg::PCT_W-1:0]          rsp_bright_percent,
   output logic                                rsp_decision_made,
   output logic                                rsp_gain_write,
   output logic [hagc_pkg::GAIN_W-1:0]         rsp_gain_value,
   output logic [hagc_pkg::STEP_W-1:0]         rsp_gain_step,
   // register writes
   input  logic                                csr_wr_en,
   input  logic [hagc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hagc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   hagc_pkg::cmd_type    cmd;
   hagc_pkg::status_type status;

   // sequencer: owns input stall and all datapath commands
   hagc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: sums, divider, statistics, gain state, result register
   hagc_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_bin_index      (req_bin_index),
      .req_bin_count      (req_bin_count),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_dark_percent   (rsp_dark_percent),
      .rsp_mid_percent    (rsp_mid_percent),
      .rsp_bright_percent (rsp_bright_percent),
      .rsp_decision_made  (rsp_decision_made),
      .rsp_gain_write     (rsp_gain_write),
      .rsp_gain_value     (rsp_gain_value),
      .rsp_gain_step      (rsp_gain_step)
   );

endmodule

@@ hdl/hagc_ctrl.sv @@
// ----------------------------------------------------------------------------
// hagc_ctrl
// Sequencer: bin intake, end-of-frame percent divisions, statistics and gain
// decision, result hand-off.
// ----------------------------------------------------------------------------
module hagc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hagc_pkg::status_type   status,
   output hagc_pkg::cmd_type      cmd
);

   hagc_pkg::state_type              state_ff, state_in;
   hagc_pkg::area_type               area_ff, area_in;
   logic [hagc_pkg::PSTEP_W-1:0]     pstep_ff, pstep_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hagc_pkg::ST_ACCUM;
         area_ff  <= hagc_pkg::AREA_DARK;
         pstep_ff <= '0;
      end else begin
         state_ff <= state_in;
         area_ff  <= area_in;
         pstep_ff <= pstep_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      area_in      = area_ff;
      pstep_in     = pstep_ff;
      cmd          = '0;
      cmd.area_sel = area_ff;
      req_stall    = 1'b1;

      case (state_ff)
         hagc_pkg::ST_ACCUM: begin
            req_stall  = 1'b0;
            cmd.acc_en = req_valid;
            if (req_valid && status.last_bin) begin
               state_in = hagc_pkg::ST_TOTAL;
            end
         end
         hagc_pkg::ST_TOTAL: begin
            cmd.total_en = 1'b1;
            area_in      = hagc_pkg::AREA_DARK;
            state_in     = hagc_pkg::ST_DIV_LOAD;
         end
         hagc_pkg::ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            pstep_in     = '0;
            state_in     = hagc_pkg::ST_DIV_STEP;
         end
         hagc_pkg::ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            pstep_in     = pstep_ff + 1'b1;
            if (pstep_ff == hagc_pkg::PSTEP_W'(hagc_pkg::PCT_BITS - 1)) begin
               state_in = hagc_pkg::ST_DIV_STORE;
            end
         end
         hagc_pkg::ST_DIV_STORE: begin
            cmd.pct_store = 1'b1;
            if (area_ff == hagc_pkg::AREA_BRIGHT) begin
               state_in = hagc_pkg::ST_STATS;
            end else begin
               area_in  = hagc_pkg::area_type'(area_ff + 1'b1);
               state_in = hagc_pkg::ST_DIV_LOAD;
            end
         end
         hagc_pkg::ST_STATS: begin
            if (status.frames_zero) begin
               cmd.stats_avg = 1'b1;
               state_in      = hagc_pkg::ST_DECIDE;
            end else begin
               cmd.stats_acc = 1'b1;
               state_in      = hagc_pkg::ST_OUT;
            end
         end
         hagc_pkg::ST_DECIDE: begin
            cmd.decide_en = 1'b1;
            state_in      = hagc_pkg::ST_GAIN;
         end
         hagc_pkg::ST_GAIN: begin
            cmd.gain_en = 1'b1;
            state_in    = hagc_pkg::ST_OUT;
         end
         hagc_pkg::ST_OUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = hagc_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = hagc_pkg::ST_ACCUM;
         end
      endcase
   end

endmodule

@@ hdl/hagc_dpath.sv @@
// ----------------------------------------------------------------------------
// hagc_dpath
// Area sums, shared percent divider, frame statistics, gain decision state,
// control registers and the result register.
// ----------------------------------------------------------------------------
module hagc_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  hagc_pkg::cmd_type                   cmd,
   output hagc_pkg::status_type                status,
   input  logic [hagc_pkg::BIN_IDX_W-1:0]      req_bin_index,
   input  logic [hagc_pkg::BIN_CNT_W-1:0]      req_bin_count,
   input  logic                                csr_wr_en,
   input  logic [hagc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [hagc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [hagc_pkg::PCT_W-1:0]          rsp_dark_percent,
   output logic [hagc_pkg::PCT_W-1:0]          rsp_mid_percent,
   output logic [hagc_pkg::PCT_W-1:0]          rsp_bright_percent,
   output logic                                rsp_decision_made,
   output logic                                rsp_gain_write,
   output logic [hagc_pkg::GAIN_W-1:0]         rsp_gain_value,
   output logic [hagc_pkg::STEP_W-1:0]         rsp_gain_step
);

   localparam int DSH_W = hagc_pkg::TOTAL_W + hagc_pkg::PCT_BITS - 1;

   // control registers
   logic                              tsel_ff, tsel_in;
   logic [7:0]                        dark_end_ff, dark_end_in;
   logic [7:0]                        bright_start_ff, bright_start_in;
   logic [6:0]                        overexp_ff, overexp_in;
   logic [hagc_pkg::RAISE_W-1:0]      raise_limit_ff, raise_limit_in;

   // frame accumulation
   logic [hagc_pkg::AREA_W-1:0]       area_ff [3];
   logic [hagc_pkg::AREA_W-1:0]       area_in [3];
   logic [hagc_pkg::TOTAL_W-1:0]      total_ff, total_in;
   logic [1:0]                        bin_area;
   logic [hagc_pkg::AREA_W:0]         acc_sum;

   // divider
   logic [hagc_pkg::SCALED_W-1:0]     rem_ff, rem_in;
   logic [DSH_W-1:0]                  dsh_ff, dsh_in;
   logic [hagc_pkg::PCT_BITS-1:0]     quo_ff, quo_in;
   logic [hagc_pkg::AREA_W-1:0]       div_area;
   logic                              div_ge;
   logic [hagc_pkg::PCT_W-1:0]        pct_ff [3];
   logic [hagc_pkg::PCT_W-1:0]        pct_in [3];

   // statistics and decision
   logic [hagc_pkg::STAT_W-1:0]       stat_ff [3];
   logic [hagc_pkg::STAT_W-1:0]       stat_in [3];
   logic [hagc_pkg::STAT_W:0]         stat_sum [3];
   logic [hagc_pkg::AVG_PROD_W-1:0]   avg_prod [3];
   logic [hagc_pkg::FRAMES_W-1:0]     frames_ff, frames_in;
   logic [hagc_pkg::STEP_W-1:0]       step_ff, step_in;
   logic                              lock_ff, lock_in;
   logic [hagc_pkg::RAISE_W-1:0]      raises_ff, raises_in;
   logic [hagc_pkg::GAIN_W-1:0]       cur_gain_ff, cur_gain_in;
   logic [hagc_pkg::GAIN_W-1:0]       prev_gain_ff, prev_gain_in;
   logic                              decided_ff, decided_in;
   logic                              wrote_ff, wrote_in;
   logic                              tgt_valid;
   logic [hagc_pkg::STEP_W-1:0]       tgt_step;
   logic [hagc_pkg::GAIN_W-1:0]       new_gain;
   logic [hagc_pkg::STAT_W-1:0]       dark_avg, bright_avg;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [hagc_pkg::PCT_W-1:0]        rsp_pct_ff [3];
   logic [hagc_pkg::PCT_W-1:0]        rsp_pct_in [3];
   logic                              rsp_decided_ff, rsp_decided_in;
   logic                              rsp_wrote_ff, rsp_wrote_in;
   logic [hagc_pkg::GAIN_W-1:0]       rsp_gain_ff, rsp_gain_in;
   logic [hagc_pkg::STEP_W-1:0]       rsp_step_ff, rsp_step_in;

   // ---- bin classification and saturating accumulate ----
   always_comb begin
      if (req_bin_index < dark_end_ff) begin
         bin_area = hagc_pkg::AREA_DARK;
      end else if (req_bin_index >= bright_start_ff) begin
         bin_area = hagc_pkg::AREA_BRIGHT;
      end else begin
         bin_area = hagc_pkg::AREA_MID;
      end
      acc_sum = {1'b0, area_ff[bin_area]} + (hagc_pkg::AREA_W + 1)'(req_bin_count);
   end

   assign status.last_bin =
      (hagc_pkg::HIST_BINS <= 2**hagc_pkg::BIN_IDX_W) &&
      (32'(req_bin_index) == 32'(hagc_pkg::LAST_BIN));
   assign status.frames_zero = (frames_ff == '0);
   assign status.out_busy    = rsp_valid_ff && rsp_stall;

   // ---- divider operand select, restoring step ----
   always_comb begin
      case (cmd.area_sel)
         hagc_pkg::AREA_DARK:   div_area = area_ff[0];
         hagc_pkg::AREA_MID:    div_area = area_ff[1];
         hagc_pkg::AREA_BRIGHT: div_area = area_ff[2];
         default:               div_area = '0;
      endcase
      div_ge = ({1'b0, rem_ff} >= dsh_ff);
   end

   // ---- decision ----
   always_comb begin
      dark_avg   = stat_ff[0];
      bright_avg = stat_ff[2];
      tgt_valid  = 1'b1;
      if (bright_avg > hagc_pkg::STAT_W'(overexp_ff)) begin
         tgt_valid = 1'b0;
         tgt_step  = '0;
      end else if (dark_avg > hagc_pkg::DARK_TH_7 || bright_avg == '0) begin
         tgt_step = hagc_pkg::STEP_W'(hagc_pkg::GAIN_STEPS - 1);
      end else if (dark_avg > hagc_pkg::DARK_TH_6) begin
         tgt_step = hagc_pkg::STEP_W'(hagc_pkg::GAIN_STEPS - 2);
      end else if (dark_avg > hagc_pkg::DARK_TH_5) begin
         tgt_step = hagc_pkg::STEP_W'(hagc_pkg::GAIN_STEPS - 3);
      end else if (dark_avg > hagc_pkg::DARK_TH_4) begin
         tgt_step = hagc_pkg::STEP_W'(hagc_pkg::GAIN_STEPS - 4);
      end else if (dark_avg > hagc_pkg::DARK_TH_3) begin
         tgt_step = hagc_pkg::STEP_W'(hagc_pkg::GAIN_STEPS - 5);
      end else begin
         tgt_valid = 1'b0;
         tgt_step  = '0;
      end
      new_gain = tsel_ff ? hagc_pkg::GAIN_TABLE_LIGHT[step_ff]
                         : hagc_pkg::GAIN_TABLE_DARK[step_ff];
   end

   // ---- next state ----
   always_comb begin
      tsel_in         = tsel_ff;
      dark_end_in     = dark_end_ff;
      bright_start_in = bright_start_ff;
      overexp_in      = overexp_ff;
      raise_limit_in  = raise_limit_ff;
      raises_in       = raises_ff;
      area_in         = area_ff;
      total_in        = total_ff;
      rem_in          = rem_ff;
      dsh_in          = dsh_ff;
      quo_in          = quo_ff;
      pct_in          = pct_ff;
      stat_in         = stat_ff;
      frames_in       = frames_ff;
      step_in         = step_ff;
      lock_in         = lock_ff;
      cur_gain_in     = cur_gain_ff;
      prev_gain_in    = prev_gain_ff;
      decided_in      = decided_ff;
      wrote_in        = wrote_ff;
      rsp_pct_in      = rsp_pct_ff;
      rsp_decided_in  = rsp_decided_ff;
      rsp_wrote_in    = rsp_wrote_ff;
      rsp_gain_in     = rsp_gain_ff;
      rsp_step_in     = rsp_step_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      for (int k = 0; k < 3; k++) begin
         stat_sum[k] = {1'b0, stat_ff[k]} + (hagc_pkg::STAT_W + 1)'(pct_ff[k]);
         avg_prod[k] = hagc_pkg::AVG_PROD_W'(stat_ff[k]) *
                       hagc_pkg::AVG_PROD_W'(hagc_pkg::AVG_RECIP);
      end

      if (csr_wr_en) begin
         case (csr_index)
            hagc_pkg::CSR_TABLE_SELECT:     tsel_in         = csr_wdata[0];
            hagc_pkg::CSR_DARK_BIN_END:     dark_end_in     = csr_wdata;
            hagc_pkg::CSR_BRIGHT_BIN_START: bright_start_in = csr_wdata;
            hagc_pkg::CSR_OVEREXPOSED_PCT:  overexp_in      = csr_wdata[6:0];
            hagc_pkg::CSR_RAISE_LIMIT: begin
               raise_limit_in = csr_wdata[hagc_pkg::RAISE_W-1:0];
               raises_in      = csr_wdata[hagc_pkg::RAISE_W-1:0];
            end
            default: ;
         endcase
      end

      if (cmd.acc_en) begin
         area_in[bin_area] = acc_sum[hagc_pkg::AREA_W] ? '1 : acc_sum[hagc_pkg::AREA_W-1:0];
      end

      if (cmd.total_en) begin
         total_in = hagc_pkg::TOTAL_W'(area_ff[0]) + hagc_pkg::TOTAL_W'(area_ff[1]) +
                    hagc_pkg::TOTAL_W'(area_ff[2]);
      end

      // area * 100 = area*64 + area*32 + area*4
      if (cmd.div_load) begin
         rem_in = (hagc_pkg::SCALED_W'(div_area) << 6) +
                  (hagc_pkg::SCALED_W'(div_area) << 5) +
                  (hagc_pkg::SCALED_W'(div_area) << 2);
         dsh_in = {total_ff, (hagc_pkg::PCT_BITS - 1)'(0)};
         quo_in = '0;
      end

      if (cmd.div_step) begin
         if (div_ge) begin
            rem_in = rem_ff - dsh_ff[hagc_pkg::SCALED_W-1:0];
         end
         quo_in = {quo_ff[hagc_pkg::PCT_BITS-2:0], div_ge};
         dsh_in = dsh_ff >> 1;
      end

      if (cmd.pct_store) begin
         pct_in[cmd.area_sel] = (total_ff == '0) ? '0 : hagc_pkg::PCT_W'(quo_ff);
      end

      if (cmd.stats_acc) begin
         frames_in  = frames_ff - 1'b1;
         decided_in = 1'b0;
         wrote_in   = 1'b0;
         for (int k = 0; k < 3; k++) begin
            stat_in[k] = stat_sum[k][hagc_pkg::STAT_W] ? hagc_pkg::STAT_W'(hagc_pkg::STAT_MAX)
                                                       : stat_sum[k][hagc_pkg::STAT_W-1:0];
            area_in[k] = '0;
         end
      end

      if (cmd.stats_avg) begin
         for (int k = 0; k < 3; k++) begin
            stat_in[k] = hagc_pkg::STAT_W'(avg_prod[k] >> hagc_pkg::AVG_SHIFT);
            area_in[k] = '0;
         end
      end

      if (cmd.decide_en) begin
         if (!tgt_valid && bright_avg > hagc_pkg::STAT_W'(overexp_ff)) begin
            if (step_ff != '0) begin
               step_in = step_ff - 1'b1;
               lock_in = 1'b1;
            end
         end
         if (tgt_valid && !lock_ff && raises_ff != '0) begin
            step_in   = tgt_step;
            raises_in = raises_ff - 1'b1;
         end
      end

      if (cmd.gain_en) begin
         decided_in = 1'b1;
         wrote_in   = 1'b0;
         if (new_gain != cur_gain_ff && new_gain != prev_gain_ff) begin
            prev_gain_in = cur_gain_ff;
            cur_gain_in  = new_gain;
            wrote_in     = 1'b1;
         end
         frames_in = hagc_pkg::FRAMES_W'(hagc_pkg::FRAMES_PER_DECISION);
         for (int k = 0; k < 3; k++) begin
            stat_in[k] = '0;
         end
      end

      if (cmd.out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_pct_in     = pct_ff;
         rsp_decided_in = decided_ff;
         rsp_wrote_in   = wrote_ff;
         rsp_gain_in    = cur_gain_ff;
         rsp_step_in    = step_ff;
      end
   end

   // ---- control state ----
   always_ff @(posedge clock) begin
      if (reset) begin
         tsel_ff         <= 1'b0;
         dark_end_ff     <= hagc_pkg::DARK_END_RST;
         bright_start_ff <= hagc_pkg::BRIGHT_START_RST;
         overexp_ff      <= hagc_pkg::OVEREXP_RST;
         raise_limit_ff  <= hagc_pkg::RAISE_LIMIT_RST;
         raises_ff       <= hagc_pkg::RAISE_LIMIT_RST;
         for (int k = 0; k < 3; k++) begin
            area_ff[k] <= '0;
            stat_ff[k] <= '0;
         end
         frames_ff       <= hagc_pkg::FRAMES_W'(hagc_pkg::FRAMES_PER_DECISION);
         step_ff         <= hagc_pkg::STEP_RST;
         lock_ff         <= 1'b0;
         cur_gain_ff     <= '0;
         prev_gain_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         tsel_ff         <= tsel_in;
         dark_end_ff     <= dark_end_in;
         bright_start_ff <= bright_start_in;
         overexp_ff      <= overexp_in;
         raise_limit_ff  <= raise_limit_in;
         raises_ff       <= raises_in;
         area_ff         <= area_in;
         stat_ff         <= stat_in;
         frames_ff       <= frames_in;
         step_ff         <= step_in;
         lock_ff         <= lock_in;
         cur_gain_ff     <= cur_gain_in;
         prev_gain_ff    <= prev_gain_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // ---- payload ----
   always_ff @(posedge clock) begin
      total_ff       <= total_in;
      rem_ff         <= rem_in;
      dsh_ff         <= dsh_in;
      quo_ff         <= quo_in;
      pct_ff         <= pct_in;
      decided_ff     <= decided_in;
      wrote_ff       <= wrote_in;
      rsp_pct_ff     <= rsp_pct_in;
      rsp_decided_ff <= rsp_decided_in;
      rsp_wrote_ff   <= rsp_wrote_in;
      rsp_gain_ff    <= rsp_gain_in;
      rsp_step_ff    <= rsp_step_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dark_percent   = rsp_pct_ff[0];
   assign rsp_mid_percent    = rsp_pct_ff[1];
   assign rsp_bright_percent = rsp_pct_ff[2];
   assign rsp_decision_made  = rsp_decided_ff;
   assign rsp_gain_write     = rsp_wrote_ff;
   assign rsp_gain_value     = rsp_gain_ff;
   assign rsp_gain_step      = rsp_step_ff;

endmodule

@@ tb/tb_histogram_auto_gain_control_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_histogram_auto_gain_control_unit
// Self-checking bench for the histogram auto gain control unit.
// ----------------------------------------------------------------------------
// Histogram bins are queued per phase and fed to the unit with random gaps,
// while the result side stalls at random. Every accepted bin goes through a
// cycle-free predictor of the area sums, frame percents, five-frame averaging
// and gain decision. Each frame-end transaction from the unit is checked field
// by field against the oldest predicted frame report. Register settings change
// between phases, only once the unit has drained.
// ----------------------------------------------------------------------------
module tb_histogram_auto_gain_control_unit;

   localparam int CLK_PERIOD     = 12;
   localparam int RESET_CYCLES   = 5;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int LONG_HOLD      = 500;
   localparam int PHASE_ITEMS    = 180;
   localparam int FRAMES_PER_AVG = 5;
   localparam int NO_TARGET      = 8;      // no upward jump requested

   localparam logic [7:0]  FRAME_END_BIN = 8'd255;
   localparam logic [23:0] COUNT_MAX     = 24'hFF_FFFF;

   // gain tables, step 0 in the low byte
   localparam logic [63:0] DARK_GAINS  = 64'hF0D0_B090_7050_3520;
   localparam logic [63:0] LIGHT_GAINS = 64'hF0D0_B0A0_8070_5540;

   typedef struct {
      logic [7:0]  index;
      logic [23:0] count;
   } hist_bin_type;

   typedef struct {
      logic [6:0] dark_pct;
      logic [6:0] mid_pct;
      logic [6:0] bright_pct;
      logic       decided;
      logic       gain_wr;
      logic [7:0] gain;
      logic [2:0] step;
   } frame_report_type;

   // leading frame of a stimulus phase
   typedef enum {LEAD_NONE, LEAD_SWEEP, LEAD_SATURATE} lead_frame_type;

   // ------------------------------------------------------------------
   // DUT signals, all inputs known from time zero
   // ------------------------------------------------------------------
   logic                                   clock              = 1'b0;
   logic                                   reset              = 1'b1;
   logic                                   req_valid          = 1'b0;
   logic                                   req_stall;
   logic [hagc_pkg::BIN_IDX_W-1:0]         req_bin_index      = '0;
   logic [hagc_pkg::BIN_CNT_W-1:0]         req_bin_count      = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall          = 1'b0;
   logic [hagc_pkg::PCT_W-1:0]             rsp_dark_percent;
   logic [hagc_pkg::PCT_W-1:0]             rsp_mid_percent;
   logic [hagc_pkg::PCT_W-1:0]             rsp_bright_percent;
   logic                                   rsp_decision_made;
   logic                                   rsp_gain_write;
   logic [hagc_pkg::GAIN_W-1:0]            rsp_gain_value;
   logic [hagc_pkg::STEP_W-1:0]            rsp_gain_step;
   logic                                   csr_wr_en          = 1'b0;
   logic [hagc_pkg::CSR_IDX_W-1:0]         csr_index          = '0;
   logic [hagc_pkg::CSR_DATA_W-1:0]        csr_wdata          = '0;

   // ------------------------------------------------------------------
   // bench bookkeeping
   // ------------------------------------------------------------------
   hist_bin_type     bin_feed_q [$];       // bins waiting for the driver
   frame_report_type report_expect_q [$];  // predicted frame reports
   int            error_count      = 0;
   int unsigned   cycle_count      = 0;
   logic          bin_taken        = 1'b0; // bin transaction at last edge
   int            gap_left         = 0;
   int            send_burst       = 0;
   int            hold_left        = 0;
   int            flow_left        = 0;
   int            long_hold_asked  = 0;
   int            long_hold_served = 0;

   // ------------------------------------------------------------------
   // predictor state: register copies and the gain control state
   // ------------------------------------------------------------------
   logic             sel_light_table = 1'b0;
   logic [7:0]       dark_end        = 8'd21;
   logic [7:0]       bright_start    = 8'd253;
   logic [6:0]       overexp_limit   = 7'd10;
   logic [2:0][31:0] zone_sum        = '0;    // dark, mid, bright pixel sums
   logic [2:0][9:0]  pct_acc         = '0;    // summed frame percents
   int               frames_to_go    = FRAMES_PER_AVG;
   logic             avg_ready       = 1'b0;
   logic [2:0]       step_idx        = 3'd3;
   logic             step_down_lock  = 1'b0;
   logic [1:0]       raises_left     = 2'd2;
   logic [7:0]       gain_now        = 8'd0;
   logic [7:0]       gain_prev       = 8'd0;

   histogram_auto_gain_control_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bin_index      (req_bin_index),
      .req_bin_count      (req_bin_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_dark_percent   (rsp_dark_percent),
      .rsp_mid_percent    (rsp_mid_percent),
      .rsp_bright_percent (rsp_bright_percent),
      .rsp_decision_made  (rsp_decision_made),
      .rsp_gain_write     (rsp_gain_write),
      .rsp_gain_value     (rsp_gain_value),
      .rsp_gain_step      (rsp_gain_step),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // gain decision on the averaged percents; returns 1 on a sensor write
   // ------------------------------------------------------------------
   function automatic logic decide_gain();
      logic [9:0] dark_avg;
      logic [9:0] bright_avg;
      int         target;
      logic [7:0] gain;
      dark_avg   = pct_acc[0];
      bright_avg = pct_acc[2];
      target     = NO_TARGET;
      if (bright_avg > overexp_limit) begin
         // overexposed: one step down unless already at step 0, and no more jumps up after that
         if (step_idx != 3'd0) begin
            step_idx       = step_idx - 3'd1;
            step_down_lock = 1'b1;
         end
      end else if (dark_avg > 95 || bright_avg == 0) begin
         target = 7;
      end else if (dark_avg > 90) begin
         target = 6;
      end else if (dark_avg > 80) begin
         target = 5;
      end else if (dark_avg > 70) begin
         target = 4;
      end else if (dark_avg > 60) begin
         target = 3;
      end
      if (target != NO_TARGET && !step_down_lock && raises_left != 2'd0) begin
         step_idx    = 3'(target);
         raises_left = raises_left - 2'd1;
      end
      gain = sel_light_table ? LIGHT_GAINS[step_idx*8 +: 8] : DARK_GAINS[step_idx*8 +: 8];
      // skip gains that would just toggle back and forth
      if (gain != gain_now && gain != gain_prev) begin
         gain_prev = gain_now;
         gain_now  = gain;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // one accepted bin: accumulate, and on the last bin predict the report
   // ------------------------------------------------------------------
   function automatic void predict_bin(logic [7:0] idx, logic [23:0] cnt);
      hagc_pkg::area_type zone;
      logic [32:0]        sum;
      logic [63:0]        total;
      logic [2:0][6:0]    pct;
      int                 acc;
      frame_report_type   rpt;
      // dark wins where the two ranges overlap
      if (idx < dark_end) begin
         zone = hagc_pkg::AREA_DARK;
      end else if (idx >= bright_start) begin
         zone = hagc_pkg::AREA_BRIGHT;
      end else begin
         zone = hagc_pkg::AREA_MID;
      end
      sum            = {1'b0, zone_sum[zone]} + cnt;
      zone_sum[zone] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];   // saturate
      if (idx != FRAME_END_BIN) return;

      total = 64'(zone_sum[0]) + 64'(zone_sum[1]) + 64'(zone_sum[2]);
      for (int k = 0; k < 3; k++) begin
         pct[k]      = (total == 0) ? 7'd0 : 7'((64'(zone_sum[k]) * 64'd100) / total);
         zone_sum[k] = '0;
      end

      rpt.decided = 1'b0;
      rpt.gain_wr = 1'b0;
      if (!avg_ready) begin
         if (frames_to_go > 0) begin
            frames_to_go--;
            for (int k = 0; k < 3; k++) begin
               acc        = pct_acc[k] + pct[k];
               pct_acc[k] = (acc > 1023) ? 10'd1023 : 10'(acc);
            end
         end else begin
            // this frame's own percents are not part of the average
            for (int k = 0; k < 3; k++) pct_acc[k] = 10'(pct_acc[k] / FRAMES_PER_AVG);
            avg_ready = 1'b1;
         end
      end
      if (avg_ready) begin
         rpt.decided  = 1'b1;
         rpt.gain_wr  = decide_gain();
         frames_to_go = FRAMES_PER_AVG;
         pct_acc      = '0;
         avg_ready    = 1'b0;
      end

      rpt.dark_pct   = pct[0];
      rpt.mid_pct    = pct[1];
      rpt.bright_pct = pct[2];
      rpt.gain       = gain_now;
      rpt.step       = step_idx;
      report_expect_q.push_back(rpt);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   function automatic void add_bin(logic [7:0] idx, logic [23:0] cnt);
      hist_bin_type b;
      b.index = idx;
      b.count = cnt;
      bin_feed_q.push_back(b);
   endfunction

   // mostly small counts so the percents spread, plus full-range patterns
   function automatic logic [23:0] random_count();
      int r;
      r = $urandom_range(9);
      if (r < 6) return 24'($urandom_range(4000));
      if (r < 8) return 24'($urandom);
      if (r == 8) return 24'd0;
      return COUNT_MAX;
   endfunction

   // Queue whole frames until n_items bins wait. Each frame is a short run
   // of bins drawn from a scene (dark and bright weights) and closed by the
   // last bin index, so a phase always ends on a frame boundary.
   function automatic void fill_phase(int n_items, lead_frame_type lead);
      int         frame_len;
      int         dark_w;
      int         bright_w;
      int         scene_left;
      int         r;
      logic [7:0] idx;
      scene_left = 0;
      dark_w     = 0;
      bright_w   = 0;
      case (lead)
         LEAD_SWEEP: begin
            for (int b = 0; b < 256; b++) add_bin(8'(b), random_count());
         end
         LEAD_SATURATE: begin
            // about 257 full bins overflow a 32-bit area sum
            idx = 8'($urandom_range(254));
            repeat (260) add_bin(idx, COUNT_MAX);
            add_bin(FRAME_END_BIN, random_count());
         end
         default: ;
      endcase
      while (bin_feed_q.size() < n_items) begin
         if (scene_left == 0) begin
            scene_left = $urandom_range(8, 2);
            dark_w     = $urandom_range(100);
            r          = $urandom_range(2);
            if (r == 0) begin
               bright_w = 0;
            end else if (r == 1) begin
               bright_w = $urandom_range(12, 1);
            end else begin
               bright_w = $urandom_range(100 - dark_w);
            end
            if (dark_w + bright_w > 100) bright_w = 100 - dark_w;
         end
         scene_left--;
         frame_len = $urandom_range(24);
         repeat (frame_len) begin
            r = $urandom_range(99);
            if (r < dark_w) begin
               idx = 8'($urandom_range(dark_end - 8'd1));
            end else if (r < dark_w + bright_w) begin
               idx = 8'($urandom_range(254, (bright_start > 8'd254) ? 254 : bright_start));
            end else begin
               idx = 8'($urandom_range(254));
            end
            add_bin(idx, random_count());
         end
         // the closing bin always lands in the bright area
         add_bin(FRAME_END_BIN, (bright_w == 0) ? 24'd0 : random_count());
      end
   endfunction

   task automatic write_reg(hagc_pkg::csr_index_type idx, logic [7:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         hagc_pkg::CSR_TABLE_SELECT:     sel_light_table = value[0];
         hagc_pkg::CSR_DARK_BIN_END:     dark_end        = value;
         hagc_pkg::CSR_BRIGHT_BIN_START: bright_start    = value;
         hagc_pkg::CSR_OVEREXPOSED_PCT:  overexp_limit   = value[6:0];
         hagc_pkg::CSR_RAISE_LIMIT:      raises_left     = value[1:0];   // reloads budget
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic configure(logic light, logic [7:0] d_end, logic [7:0] b_start,
                            logic [6:0] over, logic [1:0] raise);
      write_reg(hagc_pkg::CSR_TABLE_SELECT, {7'd0, light});
      write_reg(hagc_pkg::CSR_DARK_BIN_END, d_end);
      write_reg(hagc_pkg::CSR_BRIGHT_BIN_START, b_start);
      write_reg(hagc_pkg::CSR_OVEREXPOSED_PCT, {1'b0, over});
      write_reg(hagc_pkg::CSR_RAISE_LIMIT, {6'd0, raise});
   endtask

   // all bins sent, all reports back, then let the frame pipeline settle
   task automatic wait_drained();
      while (bin_feed_q.size() != 0 || req_valid || report_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // bin driver: next bin after a transaction or while idle, random gaps
   // with zero-gap bursts in between
   // ------------------------------------------------------------------
   always @(negedge clock) begin : bin_driver
      hist_bin_type next_bin;
      int           r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || bin_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bin_feed_q.size() != 0) begin
            next_bin = bin_feed_q.pop_front();
            req_valid     <= 1'b1;
            req_bin_index <= next_bin.index;
            req_bin_count <= next_bin.count;
            if (send_burst > 0) begin
               send_burst--;
               gap_left = 0;
            end else begin
               r = $urandom_range(99);
               if (r < 10) begin
                  send_burst = $urandom_range(80, 10);
                  gap_left   = 0;
               end else if (r < 55) begin
                  gap_left = 0;
               end else if (r < 85) begin
                  gap_left = $urandom_range(3, 1);
               end else if (r < 97) begin
                  gap_left = $urandom_range(12, 4);
               end else begin
                  gap_left = $urandom_range(60, 20);
               end
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // result side back-pressure: flowing runs, short and long holds, and
   // a very long hold on request so the unit backs up into its input
   // ------------------------------------------------------------------
   always @(negedge clock) begin : report_receiver
      int r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_served != long_hold_asked) begin
         long_hold_served++;
         hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (flow_left > 0) begin
         flow_left--;
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(99);
         if (r < 45) begin
            flow_left = $urandom_range(60, 5);
         end else if (r < 80) begin
            hold_left = $urandom_range(2);
         end else if (r < 96) begin
            hold_left = $urandom_range(14, 3);
         end else begin
            hold_left = $urandom_range(80, 20);
         end
         rsp_stall <= (r >= 45);
      end
   end

   // ------------------------------------------------------------------
   // monitor: predict on each bin transaction, check each result transaction
   // ------------------------------------------------------------------
   always @(posedge clock) begin : frame_monitor
      frame_report_type want;
      if (reset) begin
         bin_taken <= 1'b0;
      end else begin
         bin_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) predict_bin(req_bin_index, req_bin_count);
         if (rsp_valid && !rsp_stall) begin
            if (report_expect_q.size() == 0) begin
               $error("result transaction with no frame end pending");
               error_count++;
            end else begin
               want = report_expect_q.pop_front();
               check_field("dark_percent", want.dark_pct, rsp_dark_percent);
               check_field("mid_percent", want.mid_pct, rsp_mid_percent);
               check_field("bright_percent", want.bright_pct, rsp_bright_percent);
               check_field("decision_made", want.decided, rsp_decision_made);
               check_field("gain_write", want.gain_wr, rsp_gain_write);
               check_field("gain_value", want.gain, rsp_gain_value);
               check_field("gain_step", want.step, rsp_gain_step);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames on reset settings. Index and count extremes and
      // alternating bit patterns, a zero-total frame, a pure dark frame,
      // the dark and bright range boundaries, then the sixth frame which
      // runs the first decision (bright average kept under the limit).
      add_bin(8'd0,   COUNT_MAX);
      add_bin(8'd85,  24'h55_5555);
      add_bin(8'd170, 24'hAA_AAAA);
      add_bin(8'd254, 24'd1);
      add_bin(FRAME_END_BIN, 24'd0);
      add_bin(FRAME_END_BIN, 24'd0);
      add_bin(8'd3,   24'd1000);
      add_bin(FRAME_END_BIN, 24'd0);
      add_bin(8'd20,  24'd7);
      add_bin(8'd21,  24'd3);
      add_bin(8'd252, 24'd1);
      add_bin(8'd253, 24'd9);
      add_bin(FRAME_END_BIN, 24'd0);
      add_bin(8'd10,  24'd500);
      add_bin(FRAME_END_BIN, 24'd0);
      add_bin(8'd10,  24'd50);
      add_bin(FRAME_END_BIN, 24'd50);
      wait_drained();

      // Overexposure locks out upward jumps for good, so the phases that
      // exercise the raise path come first, with the limit at 100.
      // Fully overlapping ranges: all but the last bin count as dark.
      configure(1'b1, 8'd255, 8'd1, 7'd100, 2'd3);
      fill_phase(PHASE_ITEMS, LEAD_NONE);
      wait_drained();

      // no dark bins below index 1 except bin 0, bright only at the last bin
      configure(1'b0, 8'd1, 8'd255, 7'd100, 2'd3);
      fill_phase(PHASE_ITEMS, LEAD_NONE);
      wait_drained();

      // default ranges with one full 256-bin frame up front
      configure(1'b1, 8'd21, 8'd253, 7'd100, 2'd2);
      fill_phase(PHASE_ITEMS, LEAD_SWEEP);
      wait_drained();

      // random ranges; the receiver holds off long enough to back up the
      // unit while bins keep coming
      configure(1'($urandom_range(1)), 8'($urandom_range(255, 1)),
                8'($urandom_range(255, 1)), 7'd100, 2'd3);
      fill_phase(PHASE_ITEMS, LEAD_NONE);
      long_hold_asked++;
      wait_drained();

      // zero limit: any nonzero bright average steps the gain down
      configure(1'b0, 8'd128, 8'd128, 7'd0, 2'd0);
      fill_phase(PHASE_ITEMS, LEAD_NONE);
      wait_drained();

      // area sum saturation
      configure(1'b1, 8'($urandom_range(255, 1)), 8'($urandom_range(255, 1)),
                7'($urandom_range(100)), 2'd1);
      fill_phase(PHASE_ITEMS, LEAD_SATURATE);
      wait_drained();

      configure(1'($urandom_range(1)), 8'($urandom_range(255, 1)),
                8'($urandom_range(255, 1)), 7'($urandom_range(100)),
                2'($urandom_range(3)));
      fill_phase(PHASE_ITEMS, LEAD_NONE);
      wait_drained();

      configure(1'b0, 8'd21, 8'd253, 7'd10, 2'd3);
      fill_phase(PHASE_ITEMS, LEAD_NONE);
      wait_drained();

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
